// ===== rtl/core/cwa_pkg.sv =====
// Shared constants for the corner weight to alpha split unit.
// Used by the divider stage, the top level and the testbench; depends on nothing else.
package cwa_pkg;

    localparam int CORNERS = 4;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int ALPHA_BITS = 8;
    localparam logic [ALPHA_BITS-1:0] ALPHA_BUDGET = 8'd255;

endpackage

// ===== rtl/core/cwa_div_stage.sv =====
// One restoring-division step for all corners: settles one quotient bit of
// budget * weight / total. Depends on cwa_pkg.
module cwa_div_stage #(
    parameter int WEIGHT_BITS = cwa_pkg::WEIGHT_BITS_DEF,
    parameter int BIT_POS = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  logic i_degen,
    input  logic [WEIGHT_BITS+$clog2(cwa_pkg::CORNERS)-1:0] i_total,
    input  logic [cwa_pkg::CORNERS-1:0][WEIGHT_BITS+$clog2(cwa_pkg::CORNERS)
                                        +cwa_pkg::ALPHA_BITS-1:0] i_rem,
    input  logic [cwa_pkg::CORNERS-1:0][cwa_pkg::ALPHA_BITS-1:0] i_quo,
    output logic o_valid,
    output logic o_degen,
    output logic [WEIGHT_BITS+$clog2(cwa_pkg::CORNERS)-1:0] o_total,
    output logic [cwa_pkg::CORNERS-1:0][WEIGHT_BITS+$clog2(cwa_pkg::CORNERS)
                                        +cwa_pkg::ALPHA_BITS-1:0] o_rem,
    output logic [cwa_pkg::CORNERS-1:0][cwa_pkg::ALPHA_BITS-1:0] o_quo
);

    localparam int TW = WEIGHT_BITS + $clog2(cwa_pkg::CORNERS);
    localparam int DW = TW + cwa_pkg::ALPHA_BITS;

    logic [DW-1:0] divisor;
    logic [cwa_pkg::CORNERS-1:0][DW-1:0] n_rem;
    logic [cwa_pkg::CORNERS-1:0][cwa_pkg::ALPHA_BITS-1:0] n_quo;
    logic r_valid;
    logic r_degen;
    logic [TW-1:0] r_total;
    logic [cwa_pkg::CORNERS-1:0][DW-1:0] r_rem;
    logic [cwa_pkg::CORNERS-1:0][cwa_pkg::ALPHA_BITS-1:0] r_quo;

    assign divisor = DW'(i_total) << BIT_POS;

    always_comb begin
        for (int c = 0; c < cwa_pkg::CORNERS; c++) begin
            n_rem[c] = i_rem[c];
            n_quo[c] = i_quo[c];
            if (i_rem[c] >= divisor) begin
                n_rem[c] = i_rem[c] - divisor;
                n_quo[c][BIT_POS] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_degen <= i_degen;
            r_total <= i_total;
            r_rem   <= n_rem;
            r_quo   <= n_quo;
        end
    end

    assign o_valid = r_valid;
    assign o_degen = r_degen;
    assign o_total = r_total;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;

endmodule

// ===== rtl/core/corner_weight_to_alpha_split_unit.sv =====
// Top level of the corner weight to alpha split unit: input register, divider
// chain of cwa_div_stage, leftover sharing and output register. Uses cwa_pkg.
//
//   Channel  Handshake                   Beat contents
//   input    i_valid / o_stall           i_weight_0 .. i_weight_3
//   output   o_valid / i_stall           o_alpha_0 .. o_alpha_3, o_degenerate
//
// One beat is taken every cycle while the output is not stalled. The stages are
// one input stage, eight division stages (one quotient bit each), one stage that
// sums the first-pass alphas, and the output stage that shares the leftover.
// Reset is synchronous and clears only the valid bits of the stages.
// A stalled output beat freezes the whole pipeline, so nothing is lost.
module corner_weight_to_alpha_split_unit #(
    parameter int WEIGHT_BITS = cwa_pkg::WEIGHT_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  logic [WEIGHT_BITS-1:0] i_weight_0,
    input  logic [WEIGHT_BITS-1:0] i_weight_1,
    input  logic [WEIGHT_BITS-1:0] i_weight_2,
    input  logic [WEIGHT_BITS-1:0] i_weight_3,
    output logic o_valid,
    input  logic i_stall,
    output logic [cwa_pkg::ALPHA_BITS-1:0] o_alpha_0,
    output logic [cwa_pkg::ALPHA_BITS-1:0] o_alpha_1,
    output logic [cwa_pkg::ALPHA_BITS-1:0] o_alpha_2,
    output logic [cwa_pkg::ALPHA_BITS-1:0] o_alpha_3,
    output logic o_degenerate
);

    localparam int NC = cwa_pkg::CORNERS;
    localparam int AB = cwa_pkg::ALPHA_BITS;
    localparam int TW = WEIGHT_BITS + $clog2(NC);
    localparam int NW = WEIGHT_BITS + AB;
    localparam int DW = TW + AB;
    localparam int SW = AB + $clog2(NC);
    localparam int LW = $clog2(NC);
    localparam int CW = $clog2(NC + 1);

    logic en;
    logic [NC-1:0][WEIGHT_BITS-1:0] w;
    logic [TW-1:0] n_total;
    logic [NC-1:0][NW-1:0] n_num;

    logic r_in_valid;
    logic r_in_degen;
    logic [TW-1:0] r_total;
    logic [NC-1:0][NW-1:0] r_num;

    logic [AB:0] s_valid;
    logic [AB:0] s_degen;
    logic [AB:0][TW-1:0] s_total;
    logic [AB:0][NC-1:0][DW-1:0] s_rem;
    logic [AB:0][NC-1:0][AB-1:0] s_quo;

    logic [SW-1:0] sum_a;
    logic [SW-1:0] left_full;
    logic [NC-1:0] n_mask;

    logic r_a_valid;
    logic r_a_degen;
    logic [NC-1:0][AB-1:0] r_a;
    logic [NC-1:0] r_mask;
    logic [LW-1:0] r_left;

    logic [CW-1:0] nz;
    logic [CW-1:0] rem_cnt;
    logic [CW-1:0] quot;
    logic [CW-1:0] rank;
    logic [NC-1:0][AB-1:0] n_alpha;

    logic r_out_valid;
    logic r_out_degen;
    logic [NC-1:0][AB-1:0] r_alpha;

    assign en = !(r_out_valid && i_stall);
    assign o_stall = r_out_valid && i_stall;

    assign w[0] = i_weight_0;
    assign w[1] = i_weight_1;
    assign w[2] = i_weight_2;
    assign w[3] = i_weight_3;

    always_comb begin
        n_total = '0;
        for (int c = 0; c < NC; c++) begin
            n_total  = n_total + TW'(w[c]);
            n_num[c] = (NW'(w[c]) << AB) - NW'(w[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_degen <= (n_total == '0);
            r_total    <= n_total;
            r_num      <= n_num;
        end
    end

    assign s_valid[0] = r_in_valid;
    assign s_degen[0] = r_in_degen;
    assign s_total[0] = r_total;
    for (genvar c = 0; c < NC; c++) begin : g_seed
        assign s_rem[0][c] = DW'(r_num[c]);
        assign s_quo[0][c] = '0;
    end

    for (genvar k = 0; k < AB; k++) begin : g_stage
        cwa_div_stage #(
            .WEIGHT_BITS(WEIGHT_BITS),
            .BIT_POS(AB - 1 - k)
        ) u_div_stage (
            .i_clk(i_clk),
            .i_rst_n(i_rst_n),
            .i_en(en),
            .i_valid(s_valid[k]),
            .i_degen(s_degen[k]),
            .i_total(s_total[k]),
            .i_rem(s_rem[k]),
            .i_quo(s_quo[k]),
            .o_valid(s_valid[k+1]),
            .o_degen(s_degen[k+1]),
            .o_total(s_total[k+1]),
            .o_rem(s_rem[k+1]),
            .o_quo(s_quo[k+1])
        );
    end

    // The first pass loses less than one per corner, so the leftover fits LW bits.
    always_comb begin
        sum_a = '0;
        for (int c = 0; c < NC; c++) begin
            sum_a     = sum_a + SW'(s_quo[AB][c]);
            n_mask[c] = (s_quo[AB][c] != '0);
        end
        left_full = SW'(cwa_pkg::ALPHA_BUDGET) - sum_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= s_valid[AB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_degen <= s_degen[AB];
            r_a       <= s_quo[AB];
            r_mask    <= n_mask;
            r_left    <= left_full[LW-1:0];
        end
    end

    always_comb begin
        nz = CW'($countones(r_mask));
        rem_cnt = CW'(r_left);
        quot = '0;
        for (int k = 0; k < NC; k++) begin
            if (nz != '0 && rem_cnt >= nz) begin
                rem_cnt = rem_cnt - nz;
                quot    = quot + CW'(1);
            end
        end
        rank = '0;
        for (int c = 0; c < NC; c++) begin
            n_alpha[c] = r_a[c];
            if (r_mask[c]) begin
                n_alpha[c] = r_a[c] + AB'(quot) + AB'(rank < rem_cnt);
                rank = rank + CW'(1);
            end
            if (r_a_degen) begin
                n_alpha[c] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_degen <= r_a_degen;
            r_alpha     <= n_alpha;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_degenerate = r_out_degen;
    assign o_alpha_0    = r_alpha[0];
    assign o_alpha_1    = r_alpha[1];
    assign o_alpha_2    = r_alpha[2];
    assign o_alpha_3    = r_alpha[3];

endmodule

// ===== sim/corner_weight_to_alpha_split_unit_tb.sv =====
// Self-checking testbench for corner_weight_to_alpha_split_unit: directed and random weight
// sets, random idling on both channels, results checked against an in-bench alpha split.
// Depends on cwa_pkg and the unit's RTL only.
`timescale 1ns / 1ps

typedef logic [cwa_pkg::WEIGHT_BITS_DEF-1:0] t_weight_set [cwa_pkg::CORNERS];

typedef struct {
    logic [cwa_pkg::ALPHA_BITS-1:0] alpha [cwa_pkg::CORNERS];
    logic                           degenerate;
} t_alpha_split;

class alpha_split_board;
    t_alpha_split expected_alphas [$];
    int           mismatches;

    function new();
        mismatches = 0;
    endfunction

    function t_alpha_split split_alpha(t_weight_set w);
        t_alpha_split r;
        int unsigned  budget;
        int unsigned  total;
        int unsigned  left;
        int unsigned  nz;
        int unsigned  quot;
        int unsigned  rem;
        int unsigned  bumped;
        int unsigned  part [cwa_pkg::CORNERS];
        budget = 32'(cwa_pkg::ALPHA_BUDGET);
        total = 0;
        foreach (w[i]) total += 32'(w[i]);
        r.degenerate = (total == 0);
        foreach (r.alpha[i]) r.alpha[i] = '0;
        if (total == 0) begin
            return r;
        end
        left = budget;
        nz = 0;
        foreach (part[i]) begin
            part[i] = (budget * 32'(w[i])) / total;
            left -= part[i];
            if (part[i] != 0) nz++;
        end
        if (left != 0 && nz != 0) begin
            quot = left / nz;
            rem = left % nz;
            bumped = 0;
            foreach (part[i]) begin
                if (part[i] != 0) begin
                    part[i] += quot;
                    if (bumped < rem) begin
                        part[i] += 1;
                        bumped++;
                    end
                end
            end
        end
        foreach (part[i]) r.alpha[i] = part[i][cwa_pkg::ALPHA_BITS-1:0];
        return r;
    endfunction

    function void note_weights(t_weight_set w);
        expected_alphas.push_back(split_alpha(w));
    endfunction

    function int pending();
        return expected_alphas.size();
    endfunction

    function void check_alphas(t_alpha_split got);
        t_alpha_split exp;
        bit           bad;
        if (expected_alphas.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected result beat: alpha %0d %0d %0d %0d degenerate %0d",
                         got.alpha[0], got.alpha[1], got.alpha[2], got.alpha[3],
                         got.degenerate);
            end
            return;
        end
        exp = expected_alphas.pop_front();
        bad = (got.degenerate !== exp.degenerate);
        foreach (exp.alpha[i]) begin
            if (got.alpha[i] !== exp.alpha[i]) bad = 1'b1;
        end
        if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: exp %0d %0d %0d %0d deg %0d, got %0d %0d %0d %0d deg %0d",
                         exp.alpha[0], exp.alpha[1], exp.alpha[2], exp.alpha[3],
                         exp.degenerate, got.alpha[0], got.alpha[1], got.alpha[2],
                         got.alpha[3], got.degenerate);
            end
        end
    endfunction
endclass

module corner_weight_to_alpha_split_unit_tb;

    localparam int WB = cwa_pkg::WEIGHT_BITS_DEF;
    localparam int RANDOM_ITEMS = 2000;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_CYCLES = 30;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_stall;
    logic [WB-1:0]                  i_weight_0;
    logic [WB-1:0]                  i_weight_1;
    logic [WB-1:0]                  i_weight_2;
    logic [WB-1:0]                  i_weight_3;
    logic                           o_valid;
    logic                           i_stall;
    logic [cwa_pkg::ALPHA_BITS-1:0] o_alpha_0;
    logic [cwa_pkg::ALPHA_BITS-1:0] o_alpha_1;
    logic [cwa_pkg::ALPHA_BITS-1:0] o_alpha_2;
    logic [cwa_pkg::ALPHA_BITS-1:0] o_alpha_3;
    logic                           o_degenerate;

    alpha_split_board board;
    int unsigned      beat_count;
    bit               quiet_in;
    bit               quiet_out;

    corner_weight_to_alpha_split_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_weight_0   (i_weight_0),
        .i_weight_1   (i_weight_1),
        .i_weight_2   (i_weight_2),
        .i_weight_3   (i_weight_3),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_alpha_0    (o_alpha_0),
        .o_alpha_1    (o_alpha_1),
        .o_alpha_2    (o_alpha_2),
        .o_alpha_3    (o_alpha_3),
        .o_degenerate (o_degenerate)
    );

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_weight_0 = '0;
        i_weight_1 = '0;
        i_weight_2 = '0;
        i_weight_3 = '0;
        beat_count = 0;
        quiet_in = 1'b0;
        quiet_out = 1'b0;
        board = new();
    end

    always #2 i_clk = ~i_clk;

    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_weight_set random_weights();
        t_weight_set w;
        int          kind;
        int          big;
        kind = $urandom_range(0, 99);
        big = $urandom_range(0, cwa_pkg::CORNERS - 1);
        foreach (w[i]) begin
            if (kind < 30) begin
                w[i] = WB'($urandom());
            end else if (kind < 50) begin
                w[i] = ($urandom_range(0, 1) == 1) ? WB'($urandom()) : '0;
            end else if (kind < 65) begin
                w[i] = WB'($urandom_range(0, 7));
            end else if (kind < 80) begin
                w[i] = (i == big) ? WB'($urandom_range(1000, 65535))
                                  : WB'($urandom_range(0, 3));
            end else if (kind < 84) begin
                w[i] = '0;
            end else begin
                w[i] = WB'($urandom()) >> $urandom_range(0, WB - 1);
            end
        end
        return w;
    endfunction

    task automatic drive_weights(t_weight_set w);
        int gap;
        gap = pick_gap(quiet_in);
        if (gap != 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_weight_0 = w[0];
        i_weight_1 = w[1];
        i_weight_2 = w[2];
        i_weight_3 = w[3];
        do @(posedge i_clk); while (o_stall);
        board.note_weights(w);
        beat_count++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid = 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
    endtask

    initial begin
        forever begin
            repeat ($urandom_range(50, 300)) @(negedge i_clk);
            quiet_in = ($urandom_range(0, 3) == 0);
            quiet_out = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        int gap;
        @(negedge i_clk);
        forever begin
            gap = pick_gap(quiet_out);
            if (gap != 0) begin
                i_stall = 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_stall = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
    end

    initial begin
        t_alpha_split got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.alpha[0] = o_alpha_0;
                got.alpha[1] = o_alpha_1;
                got.alpha[2] = o_alpha_2;
                got.alpha[3] = o_alpha_3;
                got.degenerate = o_degenerate;
                board.check_alphas(got);
                beat_count++;
            end
        end
    end

    initial begin
        int unsigned last_count;
        int          idle;
        last_count = 0;
        idle = 0;
        forever begin
            @(negedge i_clk);
            if (beat_count == last_count) begin
                idle++;
            end else begin
                idle = 0;
            end
            last_count = beat_count;
            if (idle >= IDLE_LIMIT) begin
                $display("corner_weight_to_alpha_split_unit test failed");
                $finish;
            end
        end
    end

    initial begin
        t_weight_set directed [$];
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        directed.push_back('{16'd0, 16'd0, 16'd0, 16'd0});
        directed.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        directed.push_back('{16'd1, 16'd0, 16'd0, 16'd0});
        directed.push_back('{16'd0, 16'd1, 16'd0, 16'd0});
        directed.push_back('{16'd0, 16'd0, 16'd1, 16'd0});
        directed.push_back('{16'd0, 16'd0, 16'd0, 16'hFFFF});
        directed.push_back('{16'hFFFF, 16'd1, 16'd1, 16'd1});
        directed.push_back('{16'd1, 16'd1, 16'd1, 16'hFFFF});
        directed.push_back('{16'd1, 16'd1, 16'd1, 16'd0});
        directed.push_back('{16'd2, 16'd1, 16'd0, 16'd0});
        directed.push_back('{16'd1, 16'd1, 16'd1, 16'd1});
        directed.push_back('{16'd1, 16'd2, 16'd4, 16'd8});
        directed.push_back('{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
        directed.push_back('{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
        directed.push_back('{16'd0, 16'hFFFF, 16'd0, 16'hFFFF});
        directed.push_back('{16'h8000, 16'h8000, 16'h0001, 16'd0});
        directed.push_back('{16'd3, 16'd3, 16'd3, 16'd0});
        directed.push_back('{16'd0, 16'd0, 16'd0, 16'd0});
        directed.push_back('{16'hFFFF, 16'hFFFE, 16'd2, 16'd1});
        directed.push_back('{16'd7, 16'd0, 16'd5, 16'd0});
        foreach (directed[k]) drive_weights(directed[k]);
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) drain_results();
            drive_weights(random_weights());
        end
        i_valid = 1'b0;

        while (board.pending() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("corner_weight_to_alpha_split_unit test passed");
        end else begin
            $display("corner_weight_to_alpha_split_unit test failed");
        end
        $finish;
    end

endmodule
